// File: rtl/core/chbf_pkg.sv
`default_nettype none
package chbf_pkg;

  localparam int SampleBits  = 24;
  localparam int StateBits   = SampleBits + 4;
  localparam int CoefBits    = 18;
  localparam int MaxSections = 6;
  localparam int NumParts    = 2;
  localparam int NumRows     = NumParts * 2 * MaxSections;
  localparam int RowAw       = $clog2(NumRows);
  localparam int SecW        = $clog2(MaxSections + 1);
  localparam int DiffW       = StateBits + 1;
  localparam int ProdW       = CoefBits + 1 + DiffW;
  localparam int SumW        = ProdW - CoefBits + 1;
  localparam int HalfW       = StateBits + 1;
  localparam int ApbAw       = 3;
  localparam int ApbDw       = 32;

  localparam longint RomScale = 64'd10000000000;
  localparam longint RomHalf  = 64'd5000000000;

  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic signed [StateBits-1:0]  state_t;
  typedef logic [CoefBits-1:0]          coef_t;

  // One section's delay line: x[n-1], x[n-2], y[n-1], y[n-2]
  typedef struct packed {
    state_t x1;
    state_t x2;
    state_t y1;
    state_t y2;
  } row_t;

  typedef struct packed {
    logic            part;
    logic            branch;
    logic [SecW-1:0] sec;
    logic            first;
    logic            last_sec;
  } op_t;

  typedef struct packed {
    logic [2:0] section_count;
    logic       steep_mode;
  } cfg_t;

  typedef enum logic {
    REG_SECTION_COUNT = 1'b0,
    REG_STEEP_MODE    = 1'b1
  } reg_idx_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // Decimal ROM value (units of 1e-10) to unsigned Q0.18, round half up
  function automatic coef_t rom_q(input longint d);
    longint t;
    t = (d * (longint'(1) << CoefBits) + RomHalf) / RomScale;
    return t[CoefBits-1:0];
  endfunction

  function automatic state_t sat_state(input logic signed [SumW-1:0] v);
    if ((&v[SumW-1:StateBits-1]) || !(|v[SumW-1:StateBits-1])) begin
      return v[StateBits-1:0];
    end else if (v[SumW-1]) begin
      return {1'b1, {(StateBits-1){1'b0}}};
    end else begin
      return {1'b0, {(StateBits-1){1'b1}}};
    end
  endfunction

  function automatic sample_t sat_sample(input logic signed [HalfW-1:0] v);
    if ((&v[HalfW-1:SampleBits-1]) || !(|v[HalfW-1:SampleBits-1])) begin
      return v[SampleBits-1:0];
    end else if (v[HalfW-1]) begin
      return {1'b1, {(SampleBits-1){1'b0}}};
    end else begin
      return {1'b0, {(SampleBits-1){1'b1}}};
    end
  endfunction

  // Clamp the raw count to 1..MaxSections
  function automatic logic [SecW-1:0] act_sections(input logic [2:0] cnt);
    if (cnt == 3'd0) begin
      return SecW'(1);
    end else if (cnt > 3'(MaxSections)) begin
      return SecW'(MaxSections);
    end else begin
      return SecW'(cnt);
    end
  endfunction

  function automatic logic [RowAw-1:0] row_idx(input op_t op);
    return RowAw'(op.part ? 2 * MaxSections : 0) + RowAw'(op.branch ? MaxSections : 0)
         + RowAw'(op.sec);
  endfunction

  // [steep][count-1][branch][section]
  localparam coef_t COEF_ROM [2][6][2][6] = '{
    '{
      '{'{rom_q(64'd2364710210), rom_q(64'd0), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd7145421497), rom_q(64'd0), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd798664262), rom_q(64'd5453536511), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd2838293449), rom_q(64'd8344118915), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd602973910), rom_q(64'd4125907204), rom_q(64'd7727156537),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd2159714446), rom_q(64'd6043586265), rom_q(64'd9238861387),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd358327884), rom_q(64'd2720401434), rom_q(64'd5720571972),
          rom_q(64'd8271247620), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd1340901419), rom_q(64'd4243248713), rom_q(64'd7062921421),
          rom_q(64'd9415030942), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd236683142), rom_q(64'd1898947623), rom_q(64'd4315731806),
          rom_q(64'd6632020224), rom_q(64'd8600155425), rom_q(64'd0)},
        '{rom_q(64'd905655590), rom_q(64'd3078575724), rom_q(64'd5516782403),
          rom_q(64'd7652146864), rom_q(64'd9524772838), rom_q(64'd0)}},
      '{'{rom_q(64'd167746668), rom_q(64'd1390214882), rom_q(64'd3325011117),
          rom_q(64'd5376610531), rom_q(64'd7214184024), rom_q(64'd8821858402)},
        '{rom_q(64'd650131927), rom_q(64'd2309412999), rom_q(64'd4364942348),
          rom_q(64'd632960955), rom_q(64'd8037808679), rom_q(64'd9599687405)}}
    },
    '{
      '{'{rom_q(64'd2364710210), rom_q(64'd0), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd7145421497), rom_q(64'd0), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd1207321175), rom_q(64'd6632020224), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd3903621872), rom_q(64'd8907868327), rom_q(64'd0),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd1271414136), rom_q(64'd6528245886), rom_q(64'd9176942834),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd4005678982), rom_q(64'd8204163892), rom_q(64'd9763114516),
          rom_q(64'd0), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd771150798), rom_q(64'd4820706251), rom_q(64'd7968204713),
          rom_q(64'd9412514278), rom_q(64'd0), rom_q(64'd0)},
        '{rom_q(64'd2659685265), rom_q(64'd6651041533), rom_q(64'd8841015086),
          rom_q(64'd9820054142), rom_q(64'd0), rom_q(64'd0)}},
      '{'{rom_q(64'd514576174), rom_q(64'd3597865607), rom_q(64'd6725475931),
          rom_q(64'd8590884928), rom_q(64'd9540209868), rom_q(64'd0)},
        '{rom_q(64'd1862190625), rom_q(64'd5299513728), rom_q(64'd7810257527),
          rom_q(64'd9141815688), rom_q(64'd9854750230), rom_q(64'd0)}},
      '{'{rom_q(64'd366815022), rom_q(64'd2746317594), rom_q(64'd5610989698),
          rom_q(64'd7697418339), rom_q(64'd8922608180), rom_q(64'd9620945484)},
        '{rom_q(64'd1365476246), rom_q(64'd4231386174), rom_q(64'd6775400500),
          rom_q(64'd8398896248), rom_q(64'd9315419600), rom_q(64'd9878163707)}}
    }
  };

endpackage
`default_nettype wire

// File: rtl/core/chbf_in_if.sv
`default_nettype none
interface chbf_in_if;
  import chbf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_re;
  sample_t sample_im;

  modport source (output valid, sample_re, sample_im, input ready);
  modport sink (input valid, sample_re, sample_im, output ready);
endinterface
`default_nettype wire

// File: rtl/core/chbf_out_if.sv
`default_nettype none
interface chbf_out_if;
  import chbf_pkg::*;

  logic    valid;
  logic    ready;
  sample_t out_re;
  sample_t out_im;

  modport source (output valid, out_re, out_im, input ready);
  modport sink (input valid, out_re, out_im, output ready);
endinterface
`default_nettype wire

// File: rtl/core/chbf_regs.sv
`default_nettype none
module chbf_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [chbf_pkg::ApbAw-1:0] paddr,
  input  wire logic [chbf_pkg::ApbDw-1:0] pwdata,
  output logic      [chbf_pkg::ApbDw-1:0] prdata,
  output logic                           pready,
  output chbf_pkg::cfg_t                 cfg_o
);
  import chbf_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SECTION_COUNT: cfg_d.section_count = pwdata[2:0];
        REG_STEEP_MODE:    cfg_d.steep_mode    = pwdata[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SECTION_COUNT: prdata = ApbDw'(cfg_q.section_count);
      REG_STEEP_MODE:    prdata = ApbDw'(cfg_q.steep_mode);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.section_count <= 3'(MaxSections);
      cfg_q.steep_mode    <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/chbf_row_mem.sv
`default_nettype none
module chbf_row_mem (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      rd_en_i,
  input  wire logic [chbf_pkg::RowAw-1:0] rd_addr_i,
  output chbf_pkg::row_t                 rd_data_o,
  input  wire logic                      wr_en_i,
  input  wire logic [chbf_pkg::RowAw-1:0] wr_addr_i,
  input  chbf_pkg::row_t                 wr_data_i
);
  import chbf_pkg::*;

  row_t               mem [NumRows];
  logic [NumRows-1:0] vld_q;
  row_t               rd_q;
  logic               rv_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // A row never written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rv_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rv_q ? rd_q : '0;

endmodule
`default_nettype wire

// File: rtl/core/chbf_mac.sv
`default_nettype none
module chbf_mac (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  chbf_pkg::state_t    vin_i,
  input  chbf_pkg::row_t      row_i,
  input  chbf_pkg::coef_t     coef_i,
  output chbf_pkg::state_t    y_o,
  output chbf_pkg::row_t      row_o
);
  import chbf_pkg::*;

  logic signed [CoefBits:0]  coef_s;
  logic signed [DiffW-1:0]   diff;
  logic signed [ProdW-1:0]   prod_d, prod_q;
  logic signed [ProdW-1:0]   rnd;
  logic signed [SumW-1:0]    sum;
  state_t                    x2_q, x1_q, y1_q, vin_q;
  state_t                    y;

  // Stage 0: c * (x[n] - y[n-2])
  assign coef_s = {1'b0, coef_i};
  assign diff   = DiffW'(vin_i) - DiffW'(row_i.y2);
  assign prod_d = ProdW'(coef_s) * ProdW'(diff);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      x2_q   <= row_i.x2;
      x1_q   <= row_i.x1;
      y1_q   <= row_i.y1;
      vin_q  <= vin_i;
    end
  end

  // Stage 1: round, add x[n-2], saturate, shift the delay line
  assign rnd = prod_q + (ProdW'(1) <<< (CoefBits - 1));
  assign sum = SumW'(x2_q) + SumW'($signed(rnd[ProdW-1:CoefBits]));
  assign y   = sat_state(sum);

  assign y_o      = y;
  assign row_o.x1 = vin_q;
  assign row_o.x2 = x1_q;
  assign row_o.y1 = y;
  assign row_o.y2 = y1_q;

endmodule
`default_nettype wire

// File: rtl/core/complex_halfband_allpass_filter.sv
`default_nettype none
// A result is valid after branch A and then branch B have run all N active sections (1..6)
// for the real and imaginary parts; no new item is taken while one is in flight, and
// the next item is taken once the result has been taken.
// Sections are updated by the single multiply-add unit, one section update per cycle,
// real and imaginary chains interleaved through its two stages.
// Reset: six sections, high-rejection set; all section delays and held B outputs read zero.
module complex_halfband_allpass_filter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  chbf_in_if.sink                         sample_i,
  chbf_out_if.source                      result_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [chbf_pkg::ApbAw-1:0] paddr,
  input  wire logic [chbf_pkg::ApbDw-1:0] pwdata,
  output logic      [chbf_pkg::ApbDw-1:0] prdata,
  output logic                            pready
);
  import chbf_pkg::*;

  cfg_t            cfg;
  logic [SecW-1:0] n_act, n_m1;

  seq_state_e state_q, state_d;
  logic       in_ready, accept, final_op;

  sample_t x_q [NumParts];
  op_t     iss_q, iss_d, s0_op_q, s1_op_q;
  logic    iss_vld_q, iss_vld_d, s0_vld_q, s1_vld_q;
  coef_t   c_q;
  state_t  v_q [NumParts];
  state_t  hold_q [NumParts];
  sample_t out_q [NumParts];
  logic    out_vld_q;

  state_t  vin, y;
  row_t    rd_row, wr_row;
  logic signed [StateBits+1:0] fsum;

  chbf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign n_act = act_sections(cfg.section_count);
  assign n_m1  = n_act - SecW'(1);

  assign accept   = sample_i.valid && in_ready;
  assign final_op = s1_vld_q && s1_op_q.branch && s1_op_q.last_sec && s1_op_q.part;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: if (accept) state_d = SEQ_RUN;
      SEQ_RUN:  if (final_op) state_d = SEQ_IDLE;
      default:  state_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_q)
      SEQ_IDLE: in_ready = !out_vld_q;
      SEQ_RUN:  in_ready = 1'b0;
      default:  in_ready = 1'b0;
    endcase
  end

  // Issue order: branch A sections for both parts, then branch B
  always_comb begin
    iss_d     = iss_q;
    iss_vld_d = iss_vld_q;
    if (accept) begin
      iss_d.part     = 1'b0;
      iss_d.branch   = 1'b0;
      iss_d.sec      = '0;
      iss_d.first    = 1'b1;
      iss_d.last_sec = (n_m1 == '0);
      iss_vld_d      = 1'b1;
    end else if (iss_vld_q) begin
      if (!iss_q.part) begin
        iss_d.part = 1'b1;
      end else begin
        iss_d.part = 1'b0;
        if (iss_q.last_sec) begin
          if (iss_q.branch) begin
            iss_vld_d = 1'b0;
          end else begin
            iss_d.branch = 1'b1;
            iss_d.sec    = '0;
          end
        end else begin
          iss_d.sec = iss_q.sec + SecW'(1);
        end
      end
      iss_d.first    = (iss_d.sec == '0);
      iss_d.last_sec = (iss_d.sec == n_m1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      iss_vld_q <= 1'b0;
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      hold_q    <= '{default: '0};
    end else begin
      state_q   <= state_d;
      iss_vld_q <= iss_vld_d;
      s0_vld_q  <= iss_vld_q;
      s1_vld_q  <= s0_vld_q;
      if (final_op) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (s1_vld_q && s1_op_q.branch && s1_op_q.last_sec) begin
        hold_q[s1_op_q.part] <= y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q[0] <= sample_i.sample_re;
      x_q[1] <= sample_i.sample_im;
    end
    iss_q   <= iss_d;
    s0_op_q <= iss_q;
    s1_op_q <= s0_op_q;
    c_q     <= COEF_ROM[cfg.steep_mode][n_m1][iss_q.branch][iss_q.sec];
    if (s1_vld_q) begin
      v_q[s1_op_q.part] <= y;
    end
    // Branch A done: combine with the B output held from the previous item
    if (s1_vld_q && !s1_op_q.branch && s1_op_q.last_sec) begin
      out_q[s1_op_q.part] <= sat_sample($signed(fsum[StateBits+1:1]));
    end
  end

  assign fsum = (StateBits+2)'(y) + (StateBits+2)'(hold_q[s1_op_q.part])
              + (StateBits+2)'(1);

  assign vin = s0_op_q.first ? StateBits'(x_q[s0_op_q.part]) : v_q[s0_op_q.part];

  chbf_row_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (iss_vld_q),
    .rd_addr_i (row_idx(iss_q)),
    .rd_data_o (rd_row),
    .wr_en_i   (s1_vld_q),
    .wr_addr_i (row_idx(s1_op_q)),
    .wr_data_i (wr_row)
  );

  chbf_mac u_mac (
    .clk_i  (clk_i),
    .en_i   (s0_vld_q),
    .vin_i  (vin),
    .row_i  (rd_row),
    .coef_i (c_q),
    .y_o    (y),
    .row_o  (wr_row)
  );

  assign sample_i.ready  = in_ready;
  assign result_o.valid  = out_vld_q;
  assign result_o.out_re = out_q[0];
  assign result_o.out_im = out_q[1];

endmodule
`default_nettype wire
